FILE: sv/rv32_subset_core_step_defines.svh
// Assertion macros used by the checker file of the rv32 subset core.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RV32_SUBSET_CORE_STEP_DEFINES_SVH
`define RV32_SUBSET_CORE_STEP_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define RV32_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rv32 core port check failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define RV32_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rv32 core port check failed");

`endif

FILE: sv/r32s_pkg.sv
// Shared constants, opcodes and stage structs of the rv32 subset core.
// No dependencies; the core, exec and lsu files use it by scoped names.
package r32s_pkg;

  localparam int XLEN       = 32;
  localparam int RIDX_W     = 5;
  localparam int NREG       = 32;
  localparam int DMEM_BYTES = 4096;   // power of two, at least 16
  localparam int DADDR_W    = $clog2(DMEM_BYTES);
  localparam int LANES      = 4;
  localparam int ROWS       = DMEM_BYTES / LANES;
  localparam int ROW_W      = DADDR_W - 2;

  localparam int IN_W       = 32;
  localparam int OUT_W      = 136;
  localparam int OUT_USER_W = 3;

  localparam logic [6:0] OPC_HALT = 7'h00;
  localparam logic [6:0] OPC_R    = 7'h33;
  localparam logic [6:0] OPC_I    = 7'h13;
  localparam logic [6:0] OPC_LW   = 7'h03;
  localparam logic [6:0] OPC_SW   = 7'h23;
  localparam logic [6:0] OPC_JALR = 7'h67;
  localparam logic [6:0] OPC_BR   = 7'h63;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRA  = 3'd5;
  localparam logic [2:0] F3_ANDI = 3'd7;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_JALR = 3'd0;
  localparam logic [2:0] F3_BLT  = 3'd4;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [RIDX_W-1:0] REG_A0 = 5'd10;
  localparam logic [RIDX_W-1:0] REG_A1 = 5'd11;

  // execute stage result
  typedef struct packed {
    logic                halted;
    logic                illegal;
    logic                wb;
    logic                ld;
    logic                st;
    logic [RIDX_W-1:0]   rd;
    logic [XLEN-1:0]     val;
    logic [DADDR_W-1:0]  addr;
    logic [XLEN-1:0]     sdata;
    logic [XLEN-1:0]     npc;
  } ex_res_t;

  // data memory request from the execute stage
  typedef struct packed {
    logic               st;
    logic [DADDR_W-1:0] addr;
    logic [XLEN-1:0]    sdata;
  } mem_req_t;

  // memory stage contents
  typedef struct packed {
    logic              halted;
    logic              illegal;
    logic              wb;
    logic              ld;
    logic [RIDX_W-1:0] rd;
    logic [XLEN-1:0]   val;
    logic [XLEN-1:0]   npc;
  } m_stage_t;

endpackage

FILE: sv/rv32_subset_core_step.sv
// rv32 subset core top level: execute and memory stages, register file, output register.
// Depends on r32s_pkg, r32s_ram, r32s_exec and r32s_lsu.
// Each instruction passes the execute, memory and output registers before its result is shown.
// Throughput: one instruction per cycle while neither the output nor the memory clear stalls;
//   a dependent load feeds the next instruction directly. Reset: synchronous; pipeline empty, PC
//   and registers zero, then a data memory clearing pass during which no instruction is taken.
module rv32_subset_core_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [r32s_pkg::IN_W-1:0]       in_tdata,   // [31:0] instr_word
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] next_pc, [36:32] wb_index, [68:37] wb_value, [100:69] ret_a0,
  // [132:101] ret_a1, [135:133] zero
  output logic [r32s_pkg::OUT_W-1:0]      out_tdata,
  output logic [r32s_pkg::OUT_USER_W-1:0] out_tuser   // [0] halted, [1] illegal, [2] wb_valid
);

  logic                          adv;
  logic                          lsu_busy;
  logic                          e_vld_r;
  logic [r32s_pkg::XLEN-1:0]     e_instr_r;
  logic                          va_r;
  logic                          vb_r;
  logic [r32s_pkg::XLEN-1:0]     ra_q;
  logic [r32s_pkg::XLEN-1:0]     rb_q;
  logic [r32s_pkg::XLEN-1:0]     pc_r;
  logic [r32s_pkg::NREG-1:0]     rf_vld_r;
  logic                          l_vld_r;
  logic [r32s_pkg::RIDX_W-1:0]   l_rd_r;
  logic [r32s_pkg::XLEN-1:0]     l_val_r;
  logic                          m_vld_r;
  r32s_pkg::m_stage_t            m_r;
  r32s_pkg::m_stage_t            m_nxt;
  logic                          o_vld_r;
  logic [r32s_pkg::OUT_W-1:0]    o_tdata_r;
  logic [r32s_pkg::OUT_USER_W-1:0] o_tuser_r;
  logic [r32s_pkg::XLEN-1:0]     a0_r;
  logic [r32s_pkg::XLEN-1:0]     a1_r;
  logic [r32s_pkg::XLEN-1:0]     a0_nxt;
  logic [r32s_pkg::XLEN-1:0]     a1_nxt;
  logic [r32s_pkg::RIDX_W-1:0]   rs1;
  logic [r32s_pkg::RIDX_W-1:0]   rs2;
  logic [r32s_pkg::XLEN-1:0]     op_a;
  logic [r32s_pkg::XLEN-1:0]     op_b;
  logic [r32s_pkg::XLEN-1:0]     ld_data;
  logic [r32s_pkg::XLEN-1:0]     m_value;
  logic                          m_write;
  r32s_pkg::ex_res_t             ex_res;
  r32s_pkg::mem_req_t            mreq;

  // whole pipeline moves when the output register is free or being drained
  assign adv       = !o_vld_r || out_tready;
  assign in_tready = adv && !lsu_busy;

  assign rs1 = e_instr_r[19:15];
  assign rs2 = e_instr_r[24:20];

  // write-back leaving the memory stage
  assign m_write = m_vld_r && m_r.wb;
  assign m_value = !m_r.wb ? '0 : (m_r.ld ? ld_data : m_r.val);

  // forward: memory stage first, then the write made at the read edge, then the file
  always_comb begin
    if (m_write && m_r.rd == rs1) begin
      op_a = m_value;
    end else if (l_vld_r && l_rd_r == rs1) begin
      op_a = l_val_r;
    end else begin
      op_a = va_r ? ra_q : '0;
    end
    if (m_write && m_r.rd == rs2) begin
      op_b = m_value;
    end else if (l_vld_r && l_rd_r == rs2) begin
      op_b = l_val_r;
    end else begin
      op_b = vb_r ? rb_q : '0;
    end
  end

  r32s_exec u_exec (
    .instr (e_instr_r),
    .pc    (pc_r),
    .op_a  (op_a),
    .op_b  (op_b),
    .res   (ex_res)
  );

  always_comb begin
    mreq.st    = ex_res.st;
    mreq.addr  = ex_res.addr;
    mreq.sdata = ex_res.sdata;

    m_nxt.halted  = ex_res.halted;
    m_nxt.illegal = ex_res.illegal;
    m_nxt.wb      = ex_res.wb;
    m_nxt.ld      = ex_res.ld;
    m_nxt.rd      = ex_res.rd;
    m_nxt.val     = ex_res.val;
    m_nxt.npc     = ex_res.npc;

    a0_nxt = (m_write && m_r.rd == r32s_pkg::REG_A0) ? m_value : a0_r;
    a1_nxt = (m_write && m_r.rd == r32s_pkg::REG_A1) ? m_value : a1_r;
  end

  r32s_lsu u_lsu (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .req_vld (e_vld_r),
    .req     (mreq),
    .busy    (lsu_busy),
    .ld_data (ld_data)
  );

  // register file: two read copies sharing one write port
  r32s_ram #(
    .WIDTH (r32s_pkg::XLEN),
    .DEPTH (r32s_pkg::NREG)
  ) u_rf_a (
    .clk   (clk),
    .we    (adv && m_write),
    .waddr (m_r.rd),
    .wdata (m_value),
    .re    (adv),
    .raddr (in_tdata[19:15]),
    .rdata (ra_q)
  );

  r32s_ram #(
    .WIDTH (r32s_pkg::XLEN),
    .DEPTH (r32s_pkg::NREG)
  ) u_rf_b (
    .clk   (clk),
    .we    (adv && m_write),
    .waddr (m_r.rd),
    .wdata (m_value),
    .re    (adv),
    .raddr (in_tdata[24:20]),
    .rdata (rb_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r  <= 1'b0;
      m_vld_r  <= 1'b0;
      o_vld_r  <= 1'b0;
      pc_r     <= '0;
      rf_vld_r <= '0;
      l_vld_r  <= 1'b0;
      a0_r     <= '0;
      a1_r     <= '0;
    end else if (adv) begin
      e_vld_r <= in_tvalid && in_tready;
      m_vld_r <= e_vld_r;
      o_vld_r <= m_vld_r;
      if (e_vld_r) begin
        pc_r <= ex_res.npc;
      end
      if (m_write) begin
        rf_vld_r[m_r.rd] <= 1'b1;
        l_vld_r          <= 1'b1;
      end
      a0_r <= a0_nxt;
      a1_r <= a1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_instr_r <= in_tdata;
      va_r      <= rf_vld_r[in_tdata[19:15]];
      vb_r      <= rf_vld_r[in_tdata[24:20]];
      m_r       <= m_nxt;
      if (m_write) begin
        l_rd_r  <= m_r.rd;
        l_val_r <= m_value;
      end
      o_tdata_r <= {3'b000, a1_nxt, a0_nxt, m_value, m_r.rd, m_r.npc};
      o_tuser_r <= {m_r.wb, m_r.illegal, m_r.halted};
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_tdata_r;
  assign out_tuser  = o_tuser_r;

endmodule

FILE: sv/r32s_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module r32s_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/r32s_exec.sv
// Decode and execute logic: immediates, ALU, branch and jump targets.
// Depends on r32s_pkg.
module r32s_exec (
  input  logic [r32s_pkg::XLEN-1:0] instr,
  input  logic [r32s_pkg::XLEN-1:0] pc,
  input  logic [r32s_pkg::XLEN-1:0] op_a,
  input  logic [r32s_pkg::XLEN-1:0] op_b,
  output r32s_pkg::ex_res_t         res
);

  always_comb begin
    logic [6:0]                  opc;
    logic [2:0]                  f3;
    logic [6:0]                  f7;
    logic [r32s_pkg::RIDX_W-1:0] rd;
    logic [r32s_pkg::XLEN-1:0]   imm_i;
    logic [r32s_pkg::XLEN-1:0]   imm_s;
    logic [r32s_pkg::XLEN-1:0]   imm_b;
    logic [r32s_pkg::XLEN-1:0]   sum_i;
    logic [r32s_pkg::XLEN-1:0]   sum_s;
    logic [r32s_pkg::XLEN-1:0]   pc4;
    logic [r32s_pkg::XLEN-1:0]   val;
    logic                        wr;

    opc   = instr[6:0];
    f3    = instr[14:12];
    f7    = instr[31:25];
    rd    = instr[11:7];
    imm_i = {{20{instr[31]}}, instr[31:20]};
    imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    imm_b = {{20{instr[31]}}, instr[7], instr[30:25], instr[11:8], 1'b0};
    sum_i = op_a + imm_i;
    sum_s = op_a + imm_s;
    pc4   = pc + 32'd4;
    val   = '0;
    wr    = 1'b0;

    res         = '0;
    res.npc     = pc4;
    res.sdata   = op_b;

    case (opc)
      r32s_pkg::OPC_HALT: begin
        res.halted = 1'b1;
        res.npc    = pc;
      end
      r32s_pkg::OPC_R: begin
        wr = 1'b1;
        if (f3 == r32s_pkg::F3_ADD && f7 == r32s_pkg::F7_BASE) begin
          val = op_a + op_b;
        end else if (f3 == r32s_pkg::F3_ADD && f7 == r32s_pkg::F7_ALT) begin
          val = op_a - op_b;
        end else if (f3 == r32s_pkg::F3_XOR && f7 == r32s_pkg::F7_BASE) begin
          val = op_a ^ op_b;
        end else if (f3 == r32s_pkg::F3_SRA && f7 == r32s_pkg::F7_ALT) begin
          val = $unsigned($signed(op_a) >>> op_b[4:0]);
        end else begin
          wr          = 1'b0;
          res.illegal = 1'b1;
        end
      end
      r32s_pkg::OPC_I: begin
        if (f3 == r32s_pkg::F3_ADD) begin
          wr  = 1'b1;
          val = sum_i;
        end else if (f3 == r32s_pkg::F3_ANDI) begin
          wr  = 1'b1;
          val = op_a & imm_i;
        end else begin
          res.illegal = 1'b1;
        end
      end
      r32s_pkg::OPC_LW: begin
        if (f3 == r32s_pkg::F3_WORD) begin
          wr     = 1'b1;
          res.ld = 1'b1;
        end else begin
          res.illegal = 1'b1;
        end
      end
      r32s_pkg::OPC_SW: begin
        if (f3 == r32s_pkg::F3_WORD) begin
          res.st = 1'b1;
        end else begin
          res.illegal = 1'b1;
        end
      end
      r32s_pkg::OPC_JALR: begin
        if (f3 == r32s_pkg::F3_JALR) begin
          wr      = 1'b1;
          val     = pc4;
          res.npc = {sum_i[r32s_pkg::XLEN-1:1], 1'b0};
        end else begin
          res.illegal = 1'b1;
        end
      end
      r32s_pkg::OPC_BR: begin
        if (f3 == r32s_pkg::F3_BLT) begin
          if ($signed(op_a) < $signed(op_b)) begin
            res.npc = pc + imm_b;
          end
        end else begin
          res.illegal = 1'b1;
        end
      end
      default: begin
        res.illegal = 1'b1;
      end
    endcase

    // drop writes to x0
    res.wb   = wr && (rd != '0);
    res.rd   = res.wb ? rd : '0;
    res.val  = res.wb ? val : '0;
    res.addr = res.st ? sum_s[r32s_pkg::DADDR_W-1:0] : sum_i[r32s_pkg::DADDR_W-1:0];
  end

endmodule

FILE: sv/r32s_lsu.sv
// Data memory: four byte-lane RAMs, unaligned word access with wrap, clear after reset.
// Depends on r32s_pkg and r32s_ram.
module r32s_lsu (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      req_vld,
  input  r32s_pkg::mem_req_t        req,
  output logic                      busy,
  output logic [r32s_pkg::XLEN-1:0] ld_data
);

  logic                          clr_busy_r;
  logic                          clr_busy_nxt;
  logic [r32s_pkg::ROW_W-1:0]    clr_row_r;
  logic [r32s_pkg::ROW_W-1:0]    clr_row_nxt;
  logic [1:0]                    off_r;
  logic [7:0]                    lane_q [r32s_pkg::LANES];

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_row_nxt  = clr_row_r;
    if (clr_busy_r) begin
      clr_row_nxt = clr_row_r + 1'b1;
      if (clr_row_r == r32s_pkg::ROW_W'(r32s_pkg::ROWS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_row_r  <= clr_row_nxt;
    end
  end

  // byte offset of the load, needed when the lane data comes back
  always_ff @(posedge clk) begin
    if (adv) begin
      off_r <= req.addr[1:0];
    end
  end

  for (genvar l = 0; l < r32s_pkg::LANES; l++) begin : g_lane
    logic [1:0]                 k;
    logic [r32s_pkg::ROW_W-1:0] row;
    logic [7:0]                 wbyte;
    logic                       we;

    // lanes below the start offset belong to the next row
    assign k     = 2'(l) - req.addr[1:0];
    assign row   = req.addr[r32s_pkg::DADDR_W-1:2]
                 + r32s_pkg::ROW_W'(2'(l) < req.addr[1:0]);
    assign wbyte = 8'(req.sdata >> {k, 3'b000});
    assign we    = clr_busy_r || (adv && req_vld && req.st);

    r32s_ram #(
      .WIDTH (8),
      .DEPTH (r32s_pkg::ROWS)
    ) u_lane (
      .clk   (clk),
      .we    (we),
      .waddr (clr_busy_r ? clr_row_r : row),
      .wdata (clr_busy_r ? 8'h00 : wbyte),
      .re    (adv),
      .raddr (row),
      .rdata (lane_q[l])
    );
  end

  always_comb begin
    logic [1:0] sel;
    ld_data = '0;
    for (int b = 0; b < r32s_pkg::LANES; b++) begin
      sel = off_r + 2'(b);
      ld_data[8*b +: 8] = lane_q[sel];
    end
  end

  assign busy = clr_busy_r;

endmodule

FILE: sv/r32s_chk.sv
// Port checker for the rv32 subset core, bound to the top level.
// Depends on rv32_subset_core_step_defines.svh.
`include "rv32_subset_core_step_defines.svh"

module r32s_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic [2:0]   out_tuser
);

  // a halt changes nothing and is never flagged illegal
  `RV32_ASSERT_IMP(a_halt_quiet, out_tvalid && out_tuser[0], !out_tuser[1] && !out_tuser[2])
  // an illegal encoding writes nothing
  `RV32_ASSERT_IMP(a_illegal_nowb, out_tvalid && out_tuser[1], !out_tuser[2] && !out_tuser[0])
  // no write-back: index and value read as zero
  `RV32_ASSERT_IMP(a_wb_zero, out_tvalid && !out_tuser[2], out_tdata[68:32] == 37'd0)
  // a write-back never targets x0
  `RV32_ASSERT_IMP(a_wb_idx, out_tvalid && out_tuser[2], out_tdata[36:32] != 5'd0)
  // a stalled result holds
  `RV32_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind rv32_subset_core_step r32s_chk u_chk (.*);
